>>> hdl/heightmap_to_normal_map_assert.svh
// ----------------------------------------------------------------------------
// heightmap_to_normal_map assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHTMAP_TO_NORMAL_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define HNM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heightmap_to_normal_map: check failed");
`define HNM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heightmap_to_normal_map: check failed");
`else
`define HNM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HNM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/hnm_pkg.sv
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared types and constants of the heightmap to normal map block.
// ----------------------------------------------------------------------------
`default_nettype none
package hnm_pkg;

  localparam int MAX_SIDE_LOG2_DEF = 8;
  localparam int FIFO_DEPTH = 16;
  localparam int STEPS = 8;

  localparam logic [1:0] CFG_WIDTH_LOG2  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_LOG2 = 2'd1;
  localparam logic [1:0] CFG_Z_TERM      = 2'd2;

  localparam logic [3:0]  SIDE_LOG2_RST = 4'd8;
  localparam logic [15:0] Z_TERM_RST    = 16'd16384;
  localparam logic [15:0] SQ255         = 16'd65025;

  typedef struct packed {
    logic [7:0]  hc;
    logic [7:0]  hr;
    logic [7:0]  hd;
    logic [15:0] z;
    logic [7:0]  ref_h;
    logic        last;
  } norm_in_t;

  typedef struct packed {
    logic [7:0] normal_x;
    logic [7:0] normal_y;
    logic [7:0] normal_z;
    logic [7:0] relief;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/hnm_store.sv
// ----------------------------------------------------------------------------
// hnm_store
// Single-port height memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module hnm_store import hnm_pkg::*; #(
  parameter int AW = 2 * MAX_SIDE_LOG2_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hdl/hnm_lane.sv
// ----------------------------------------------------------------------------
// hnm_lane
// Pipelined bit-by-bit search of one output byte, three stages per bit.
// ----------------------------------------------------------------------------
`default_nettype none
module hnm_lane import hnm_pkg::*; (
  input  logic        clk,
  input  logic [16:0] dsum,
  input  logic [31:0] zsq,
  input  logic [47:0] b2,
  input  logic        bneg,
  output logic [7:0]  k
);

  logic [7:0]  k_p [1:STEPS];
  logic [16:0] d_p [1:STEPS];
  logic [31:0] z_p [1:STEPS];
  logic [47:0] b_p [1:STEPS];
  logic        n_p [1:STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [7:0]  k_i;
    logic [16:0] d_i;
    logic [31:0] z_i;
    logic [47:0] b_i;
    logic        n_i;
    logic [7:0]  cand;
    logic [8:0]  tw;
    logic [8:0]  amag;
    logic [7:0]  cand_a, k_a, cand_b, k_b;
    logic [15:0] a2_a;
    logic        apos_a, apos_b, n_a, n_b;
    logic [16:0] d_a, d_b;
    logic [31:0] z_a, z_b;
    logic [47:0] b_a, b_b;
    logic [32:0] m1_b;
    logic [47:0] m2_b;
    logic [49:0] prod;
    logic        fits;

    if (s == 0) begin : g_first
      assign k_i = '0;
      assign d_i = dsum;
      assign z_i = zsq;
      assign b_i = b2;
      assign n_i = bneg;
    end else begin : g_rest
      assign k_i = k_p[s];
      assign d_i = d_p[s];
      assign z_i = z_p[s];
      assign b_i = b_p[s];
      assign n_i = n_p[s];
    end

    assign cand = k_i | (8'h80 >> s);
    assign tw   = {cand, 1'b0};
    assign amag = cand[7] ? (tw - 9'd255) : (9'd255 - tw);

    always_ff @(posedge clk) begin
      cand_a <= cand;
      apos_a <= cand[7];
      a2_a   <= amag[7:0] * amag[7:0];
      k_a    <= k_i;
      d_a    <= d_i;
      z_a    <= z_i;
      b_a    <= b_i;
      n_a    <= n_i;
    end

    always_ff @(posedge clk) begin
      m1_b   <= a2_a * d_a;
      m2_b   <= a2_a * z_a;
      cand_b <= cand_a;
      apos_b <= apos_a;
      k_b    <= k_a;
      d_b    <= d_a;
      z_b    <= z_a;
      b_b    <= b_a;
      n_b    <= n_a;
    end

    assign prod = {1'b0, m1_b, 16'b0} + {2'b0, m2_b};
    assign fits = apos_b ? (!n_b && (prod <= {2'b0, b_b}))
                         : (!n_b || (prod >= {2'b0, b_b}));

    always_ff @(posedge clk) begin
      k_p[s+1] <= fits ? cand_b : k_b;
      d_p[s+1] <= d_b;
      z_p[s+1] <= z_b;
      b_p[s+1] <= b_b;
      n_p[s+1] <= n_b;
    end
  end

  assign k = k_p[STEPS];

endmodule
`default_nettype wire

>>> hdl/hnm_norm.sv
// ----------------------------------------------------------------------------
// hnm_norm
// Slope, squared terms and three search lanes for one normal pixel.
// ----------------------------------------------------------------------------
`default_nettype none
module hnm_norm import hnm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     pix_valid,
  input  norm_in_t pix,
  output logic     res_valid,
  output result_t  res
);

  localparam int LAT = 3 * STEPS;

  logic              v0, v1, v2;
  logic signed [8:0] dx0, dy0;
  logic [15:0]       z0;
  logic [7:0]        rel0, rel1, rel2;
  logic              last0, last1, last2;
  logic [9:0]        relsum;
  logic signed [17:0] px, py;
  logic [15:0]       dx2_1, dy2_1;
  logic [31:0]       zsq1, zsq2;
  logic              nx1, ny1;
  logic [16:0]       d2;
  logic [31:0]       bx, by;
  logic [47:0]       bz;
  logic [47:0]       b2x, b2y, b2z;
  logic              nx2, ny2, zero2;
  logic [7:0]        kx, ky, kz;

  logic       sb_v    [0:LAT-1];
  logic [7:0] sb_rel  [0:LAT-1];
  logic       sb_last [0:LAT-1];
  logic       sb_zero [0:LAT-1];

  assign relsum = {2'b0, pix.hc} + 10'd256 - {2'b0, pix.ref_h};

  always_ff @(posedge clk) begin
    dx0   <= $signed({1'b0, pix.hc}) - $signed({1'b0, pix.hr});
    dy0   <= $signed({1'b0, pix.hc}) - $signed({1'b0, pix.hd});
    z0    <= pix.z;
    rel0  <= relsum[8:1] + 8'd255;
    last0 <= pix.last;
  end

  assign px = dx0 * dx0;
  assign py = dy0 * dy0;

  always_ff @(posedge clk) begin
    dx2_1 <= px[15:0];
    dy2_1 <= py[15:0];
    zsq1  <= z0 * z0;
    nx1   <= dx0 > 9'sd0;
    ny1   <= dy0 > 9'sd0;
    rel1  <= rel0;
    last1 <= last0;
  end

  assign bx = SQ255 * dx2_1;
  assign by = SQ255 * dy2_1;
  assign bz = SQ255 * zsq1;

  always_ff @(posedge clk) begin
    d2    <= {1'b0, dx2_1} + {1'b0, dy2_1};
    zsq2  <= zsq1;
    b2x   <= {bx, 16'b0};
    b2y   <= {by, 16'b0};
    b2z   <= bz;
    nx2   <= nx1;
    ny2   <= ny1;
    zero2 <= (dx2_1 == '0) && (dy2_1 == '0) && (zsq1 == '0);
    rel2  <= rel1;
    last2 <= last1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= pix_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  hnm_lane u_lane_x (
    .clk(clk), .dsum(d2), .zsq(zsq2), .b2(b2x), .bneg(nx2), .k(kx)
  );
  hnm_lane u_lane_y (
    .clk(clk), .dsum(d2), .zsq(zsq2), .b2(b2y), .bneg(ny2), .k(ky)
  );
  hnm_lane u_lane_z (
    .clk(clk), .dsum(d2), .zsq(zsq2), .b2(b2z), .bneg(1'b0), .k(kz)
  );

  for (genvar i = 0; i < LAT; i++) begin : g_sb
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        sb_rel[i]  <= rel2;
        sb_last[i] <= last2;
        sb_zero[i] <= zero2;
        if (rst) begin
          sb_v[i] <= 1'b0;
        end else begin
          sb_v[i] <= v2;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        sb_rel[i]  <= sb_rel[i-1];
        sb_last[i] <= sb_last[i-1];
        sb_zero[i] <= sb_zero[i-1];
        if (rst) begin
          sb_v[i] <= 1'b0;
        end else begin
          sb_v[i] <= sb_v[i-1];
        end
      end
    end
  end

  assign res_valid    = sb_v[LAT-1];
  assign res.normal_x = sb_zero[LAT-1] ? 8'd127 : kx;
  assign res.normal_y = sb_zero[LAT-1] ? 8'd127 : ky;
  assign res.normal_z = sb_zero[LAT-1] ? 8'd255 : kz;
  assign res.relief   = sb_rel[LAT-1];
  assign res.last     = sb_last[LAT-1];

endmodule
`default_nettype wire

>>> hdl/hnm_ofifo.sv
// ----------------------------------------------------------------------------
// hnm_ofifo
// Result queue in front of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none
module hnm_ofifo import hnm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t wdata,
  input  logic    pop,
  output logic    valid,
  output result_t rdata
);

  localparam int PTRW = $clog2(FIFO_DEPTH);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  result_t         q [0:FIFO_DEPTH-1];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign valid = count != '0;
  assign rdata = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/heightmap_to_normal_map.sv
// ----------------------------------------------------------------------------
// heightmap_to_normal_map
// Forward-difference normal map from a power-of-two heightmap.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind 0 stores height at the next load
// position in raster order, kind 1 requests the next normal pixel.
// Output channel (out_valid/out_ready): one result per pixel request, in order.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 width_log2,
// index 1 height_log2, index 2 z_term; write only while the block is idle.
// Pacing: a pixel request holds off further input while it reads its own,
// right and lower height through the single memory port.
// Pipeline: a request passes 3 memory reads, 3 slope/square stages and 8
// search bits of 3 stages each before its result enters the output queue.
// Stall: results queue in a 16-entry buffer; requests are held off once 16
// are in flight or queued, so nothing is lost while the receiver stalls.
// Reset: positions, reference height and queue clear; config returns to 8,
// 8, 16384. The height memory is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
`default_nettype none
module heightmap_to_normal_map import hnm_pkg::*; #(
  parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  normal_x,
  output logic [7:0]  normal_y,
  output logic [7:0]  normal_z,
  output logic [7:0]  relief,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = 2 * MAX_SIDE_LOG2;
  localparam int PW = AW + 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [3:0]    width_log2, height_log2;
  logic [15:0]   z_term;
  logic [3:0]    wl, hl;
  logic [PW-1:0] npix, mask, wm, hm;
  logic [PW-1:0] load_position, emit_position;
  logic [PW:0]   lp1, ep1;
  logic [7:0]    reference_height;
  logic [AW-1:0] la, ea, ex, ey, ar, ad, ar_reg, ad_reg, maddr;
  logic          accept, acc_load, acc_emit, emit_last;
  logic [2:0]    ph;
  logic [7:0]    rdata, hc_reg, hr_reg, ref_cap;
  logic          last_cap;
  logic [CW-1:0] credit;
  logic          pop, res_valid;
  norm_in_t      pix;
  result_t       res, qout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= SIDE_LOG2_RST;
      height_log2 <= SIDE_LOG2_RST;
      z_term      <= Z_TERM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH_LOG2:  width_log2  <= cfg_data[3:0];
        CFG_HEIGHT_LOG2: height_log2 <= cfg_data[3:0];
        CFG_Z_TERM:      z_term      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wl   = (width_log2 > 4'(MAX_SIDE_LOG2)) ? 4'(MAX_SIDE_LOG2) : width_log2;
  assign hl   = (height_log2 > 4'(MAX_SIDE_LOG2)) ? 4'(MAX_SIDE_LOG2) : height_log2;
  assign npix = PW'(1) << ({1'b0, wl} + {1'b0, hl});
  assign mask = npix - 1'b1;
  assign wm   = (PW'(1) << wl) - 1'b1;
  assign hm   = (PW'(1) << hl) - 1'b1;

  assign accept   = in_valid && in_ready;
  assign acc_load = accept && !kind;
  assign acc_emit = accept && kind;

  assign la = load_position[AW-1:0] & mask[AW-1:0];
  assign ea = emit_position[AW-1:0] & mask[AW-1:0];
  assign ex = ea & wm[AW-1:0];
  assign ey = ea >> wl;
  assign ar = (ex == wm[AW-1:0]) ? ea - wm[AW-1:0] : ea + 1'b1;
  assign ad = (ey == hm[AW-1:0]) ? ea - (hm[AW-1:0] << wl) : ea + wm[AW-1:0] + 1'b1;

  assign lp1       = {1'b0, load_position} + 1'b1;
  assign ep1       = {1'b0, emit_position} + 1'b1;
  assign emit_last = ep1 >= {1'b0, npix};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position    <= '0;
      emit_position    <= '0;
      reference_height <= '0;
      ph               <= '0;
      credit           <= '0;
    end else begin
      ph     <= {ph[1:0], acc_emit};
      credit <= credit + CW'(acc_emit) - CW'(pop);
      if (acc_load) begin
        load_position <= (lp1 >= {1'b0, npix}) ? '0 : lp1[PW-1:0];
        if (la == '0) begin
          reference_height <= height;
        end
      end
      if (acc_emit) begin
        emit_position <= emit_last ? '0 : ep1[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_emit) begin
      ar_reg   <= ar;
      ad_reg   <= ad;
      ref_cap  <= reference_height;
      last_cap <= emit_last;
    end
    if (ph[0]) begin
      hc_reg <= rdata;
    end
    if (ph[1]) begin
      hr_reg <= rdata;
    end
  end

  assign maddr = acc_emit ? ea : ph[0] ? ar_reg : ph[1] ? ad_reg : la;

  hnm_store #(.AW(AW)) u_store (
    .clk(clk), .we(acc_load), .addr(maddr), .wdata(height), .rdata(rdata)
  );

  assign in_ready = !ph[0] && !ph[1] && (credit < CW'(FIFO_DEPTH));

  assign pix.hc    = hc_reg;
  assign pix.hr    = hr_reg;
  assign pix.hd    = rdata;
  assign pix.z     = z_term;
  assign pix.ref_h = ref_cap;
  assign pix.last  = last_cap;

  hnm_norm u_norm (
    .clk(clk), .rst(rst), .pix_valid(ph[2]), .pix(pix),
    .res_valid(res_valid), .res(res)
  );

  assign pop = out_valid && out_ready;

  hnm_ofifo u_ofifo (
    .clk(clk), .rst(rst), .push(res_valid), .wdata(res), .pop(pop),
    .valid(out_valid), .rdata(qout)
  );

  assign normal_x = qout.normal_x;
  assign normal_y = qout.normal_y;
  assign normal_z = qout.normal_z;
  assign relief   = qout.relief;
  assign last     = qout.last;

`include "heightmap_to_normal_map_assert.svh"

  `HNM_ASSERT_IMPL(a_credit_bound, clk, rst, 1'b1, credit <= CW'(FIFO_DEPTH))
  `HNM_ASSERT_NEXT(a_emit_reads, clk, rst, acc_emit, ph[0] && !in_ready)
  `HNM_ASSERT_IMPL(a_out_counted, clk, rst, out_valid, credit != '0)

endmodule
`default_nettype wire
